// File: src/md4_pkg.sv
`timescale 1ns / 1ps
// md4_pkg: shared types, constants and step tables for the MD4 hash engine.
// Depends on nothing; used by md4_hash_engine and md4_step_unit.

package md4_pkg;

    // Input transfer payload: one message word and its flags
    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic        first_word;
        logic        last_word;
    } md4_word_t;

    // Output transfer payload: the four digest words
    typedef struct packed {
        logic [31:0] digest_a;
        logic [31:0] digest_b;
        logic [31:0] digest_c;
        logic [31:0] digest_d;
    } md4_digest_t;

    // Four 32-bit words: chaining value or working registers, index 0 first
    typedef logic [3:0][31:0] md4_regs_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_STEP,
        ST_FOLD,
        ST_EMIT
    } md4_fsm_t;

    localparam logic [31:0] IV_A     = 32'h67452301;
    localparam logic [31:0] IV_B     = 32'hefcdab89;
    localparam logic [31:0] IV_C     = 32'h98badcfe;
    localparam logic [31:0] IV_D     = 32'h10325476;
    localparam logic [31:0] K_ROUND1 = 32'h5a827999;
    localparam logic [31:0] K_ROUND2 = 32'h6ed9eba1;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    localparam logic [2:0] FULL_WORD_BYTES = 3'd4;
    localparam logic [5:0] LAST_STEP       = 6'd47;
    localparam logic [3:0] LAST_POS        = 4'd15;
    localparam logic [3:0] LEN_LO_POS      = 4'd14;

    localparam md4_regs_t IV_WORDS = {IV_D, IV_C, IV_B, IV_A};

    // Message word used by a step: in order, then column order, then bit-reversed
    function automatic logic [3:0] md4_word_index(input logic [5:0] step);
        logic [3:0] i;
        i = step[3:0];
        case (step[5:4])
            2'd0:    return i;
            2'd1:    return {i[1:0], i[3:2]};
            default: return {i[0], i[1], i[2], i[3]};
        endcase
    endfunction

    // Left rotate amount for a step
    function automatic logic [4:0] md4_rot_amount(input logic [5:0] step);
        case ({step[5:4], step[1:0]})
            4'b00_00: return 5'd3;
            4'b00_01: return 5'd7;
            4'b00_10: return 5'd11;
            4'b00_11: return 5'd19;
            4'b01_00: return 5'd3;
            4'b01_01: return 5'd5;
            4'b01_10: return 5'd9;
            4'b01_11: return 5'd13;
            4'b10_00: return 5'd3;
            4'b10_01: return 5'd9;
            4'b10_10: return 5'd11;
            4'b10_11: return 5'd15;
            default:  return 5'd0;
        endcase
    endfunction

    // Rotate a word left
    function automatic logic [31:0] md4_rotl(input logic [31:0] v, input logic [4:0] s);
        logic [63:0] dbl;
        dbl = {v, v} << s;
        return dbl[63:32];
    endfunction

endpackage

// File: src/md4_hash_engine.sv
`timescale 1ns / 1ps
// md4_hash_engine: streaming MD4 top level with padding sequencer.
// Depends on md4_pkg, md4_block_buffer and md4_step_unit.
//
//   channel | handshake                  | payload
//   --------+----------------------------+-----------------------------
//   word    | word_valid / word_stall    | md4_word_t   (message word)
//   digest  | digest_valid / digest_stall| md4_digest_t (four words)
//
// A word that does not fill a block is taken while the engine stays idle. A word
// that fills a block stalls new words through load, steps and fold: the shared
// step unit runs one MD4 step per cycle, fed by the registered buffer read. A last
// word adds padding writes, one or two more block runs and an emit state.
// Reset clears control and loads the initial chaining value; the buffer is
// not cleared. A held digest does not block new words, only the next digest.

module md4_hash_engine (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 word_valid,
    output logic                 word_stall,
    input  md4_pkg::md4_word_t   word,
    output logic                 digest_valid,
    input  logic                 digest_stall,
    output md4_pkg::md4_digest_t digest
);

    md4_pkg::md4_fsm_t    state_reg, state_next;
    logic [5:0]           step_reg, step_next;
    logic [3:0]           pos_reg, pos_next;
    logic [63:0]          len_reg, len_next;
    md4_pkg::md4_regs_t   cv_reg, cv_next;
    md4_pkg::md4_regs_t   wk_reg, wk_next;
    logic                 pad_reg, pad_next;
    logic                 extra80_reg, extra80_next;
    logic                 lo_done_reg, lo_done_next;
    logic                 tail_done_reg, tail_done_next;
    logic                 out_valid_reg, out_valid_next;
    md4_pkg::md4_digest_t out_data_reg, out_data_next;

    logic                 wr_en;
    logic [3:0]           wr_addr;
    logic [31:0]          wr_data;
    logic [3:0]           rd_addr;
    logic [31:0]          rd_data;
    logic [31:0]          step_result;

    logic [2:0]           count_sat;
    logic [31:0]          tail_word;
    logic [63:0]          len_base;
    logic [3:0]           pos_base;
    logic [63:0]          bit_len;

    md4_block_buffer u_buffer (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    md4_step_unit u_step (
        .regs     (wk_reg),
        .msg_word (rd_data),
        .step     (step_reg),
        .result   (step_result)
    );

    assign word_stall   = (state_reg != md4_pkg::ST_IDLE);
    assign digest_valid = out_valid_reg;
    assign digest       = out_data_reg;
    assign bit_len      = {len_reg[60:0], 3'b000};

    // Saturate the byte count and build the final data word with its pad byte
    always_comb
    begin
        count_sat = (word.byte_count > md4_pkg::FULL_WORD_BYTES) ?
                    md4_pkg::FULL_WORD_BYTES : word.byte_count;
        case (count_sat)
            3'd0:    tail_word = {24'h0, md4_pkg::PAD_BYTE};
            3'd1:    tail_word = {16'h0, md4_pkg::PAD_BYTE, word.data_word[7:0]};
            3'd2:    tail_word = {8'h0, md4_pkg::PAD_BYTE, word.data_word[15:0]};
            3'd3:    tail_word = {md4_pkg::PAD_BYTE, word.data_word[23:0]};
            default: tail_word = word.data_word;
        endcase
        len_base = word.first_word ? 64'd0 : len_reg;
        pos_base = word.first_word ? 4'd0 : pos_reg;
    end

    // Sequencer: next state and datapath controls
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        pos_next       = pos_reg;
        len_next       = len_reg;
        cv_next        = cv_reg;
        wk_next        = wk_reg;
        pad_next       = pad_reg;
        extra80_next   = extra80_reg;
        lo_done_next   = lo_done_reg;
        tail_done_next = tail_done_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && digest_stall;
        wr_en          = 1'b0;
        wr_addr        = pos_reg;
        wr_data        = 32'h0;
        rd_addr        = 4'd0;

        case (state_reg)
            md4_pkg::ST_IDLE:
            begin
                if (word_valid)
                begin
                    if (word.first_word)
                    begin
                        cv_next = md4_pkg::IV_WORDS;
                    end
                    wr_en    = 1'b1;
                    wr_addr  = pos_base;
                    wr_data  = word.last_word ? tail_word : word.data_word;
                    len_next = len_base + (word.last_word ? {61'h0, count_sat} : 64'd4);
                    pos_next = pos_base + 4'd1;
                    if (word.last_word)
                    begin
                        pad_next     = 1'b1;
                        extra80_next = (count_sat == md4_pkg::FULL_WORD_BYTES);
                    end
                    if (pos_base == md4_pkg::LAST_POS)
                    begin
                        state_next = md4_pkg::ST_LOAD;
                    end
                    else if (word.last_word)
                    begin
                        state_next = md4_pkg::ST_PAD;
                    end
                end
            end

            md4_pkg::ST_PAD:
            begin
                // Write pad byte word, zeros or the bit length
                wr_en    = 1'b1;
                pos_next = pos_reg + 4'd1;
                if (extra80_reg)
                begin
                    wr_data      = {24'h0, md4_pkg::PAD_BYTE};
                    extra80_next = 1'b0;
                end
                else if (pos_reg == md4_pkg::LEN_LO_POS)
                begin
                    wr_data      = bit_len[31:0];
                    lo_done_next = 1'b1;
                end
                else if (pos_reg == md4_pkg::LAST_POS && lo_done_reg)
                begin
                    wr_data        = bit_len[63:32];
                    tail_done_next = 1'b1;
                end
                if (pos_reg == md4_pkg::LAST_POS)
                begin
                    state_next = md4_pkg::ST_LOAD;
                end
            end

            md4_pkg::ST_LOAD:
            begin
                // Prefetch the first step's word, copy the chaining value
                rd_addr    = md4_pkg::md4_word_index(6'd0);
                wk_next    = cv_reg;
                step_next  = 6'd0;
                state_next = md4_pkg::ST_STEP;
            end

            md4_pkg::ST_STEP:
            begin
                // Run one step, rotate register roles, prefetch the next word
                rd_addr    = md4_pkg::md4_word_index(step_reg + 6'd1);
                wk_next[0] = wk_reg[3];
                wk_next[1] = step_result;
                wk_next[2] = wk_reg[1];
                wk_next[3] = wk_reg[2];
                step_next  = step_reg + 6'd1;
                if (step_reg == md4_pkg::LAST_STEP)
                begin
                    step_next  = 6'd0;
                    state_next = md4_pkg::ST_FOLD;
                end
            end

            md4_pkg::ST_FOLD:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    cv_next[i] = cv_reg[i] + wk_reg[i];
                end
                if (tail_done_reg)
                begin
                    state_next = md4_pkg::ST_EMIT;
                end
                else if (pad_reg)
                begin
                    state_next = md4_pkg::ST_PAD;
                end
                else
                begin
                    state_next = md4_pkg::ST_IDLE;
                end
            end

            md4_pkg::ST_EMIT:
            begin
                // Hand the digest to the output register once it is free
                if (!out_valid_reg || !digest_stall)
                begin
                    out_data_next.digest_a = cv_reg[0];
                    out_data_next.digest_b = cv_reg[1];
                    out_data_next.digest_c = cv_reg[2];
                    out_data_next.digest_d = cv_reg[3];
                    out_valid_next = 1'b1;
                    len_next       = 64'd0;
                    pos_next       = 4'd0;
                    pad_next       = 1'b0;
                    extra80_next   = 1'b0;
                    lo_done_next   = 1'b0;
                    tail_done_next = 1'b0;
                    state_next     = md4_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = md4_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold control state and chaining value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= md4_pkg::ST_IDLE;
            step_reg      <= 6'd0;
            pos_reg       <= 4'd0;
            len_reg       <= 64'd0;
            cv_reg        <= md4_pkg::IV_WORDS;
            pad_reg       <= 1'b0;
            extra80_reg   <= 1'b0;
            lo_done_reg   <= 1'b0;
            tail_done_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            pos_reg       <= pos_next;
            len_reg       <= len_next;
            cv_reg        <= cv_next;
            pad_reg       <= pad_next;
            extra80_reg   <= extra80_next;
            lo_done_reg   <= lo_done_next;
            tail_done_reg <= tail_done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Advance working registers and digest payload
    always_ff @(posedge clk)
    begin
        wk_reg       <= wk_next;
        out_data_reg <= out_data_next;
    end

    // Step counter rests at zero outside the step loop
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != md4_pkg::ST_STEP) |-> (step_reg == 6'd0))
        else $error("step counter not at zero outside step loop");

    // A digest transfer is only offered after the emit state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == md4_pkg::ST_EMIT))
        else $error("digest raised outside emit");

    // A final word always leads into padding or a block run
    assert property (@(posedge clk) disable iff (!rst_n)
        (word_valid && !word_stall && word.last_word) |=>
        (state_reg == md4_pkg::ST_PAD || state_reg == md4_pkg::ST_LOAD))
        else $error("final word did not start padding");

    // Emit only happens on a block boundary with the length written
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == md4_pkg::ST_EMIT) |-> (pos_reg == 4'd0 && lo_done_reg && !extra80_reg))
        else $error("emit reached with incomplete padding");

endmodule

// File: src/md4_block_buffer.sv
`timescale 1ns / 1ps
// md4_block_buffer: 16 x 32 message block store, one write and one registered read port.
// Depends on nothing.

module md4_block_buffer (
    input  logic        clk,
    input  logic        wr_en,
    input  logic [3:0]  wr_addr,
    input  logic [31:0] wr_data,
    input  logic [3:0]  rd_addr,
    output logic [31:0] rd_data
);

    logic [31:0] mem [16];
    logic [31:0] rd_data_reg;

    // Write one word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Register the read word
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/md4_step_unit.sv
`timescale 1ns / 1ps
// md4_step_unit: one MD4 step (round function, additions, rotate), shared by all 48 steps.
// Depends on md4_pkg.

module md4_step_unit (
    input  md4_pkg::md4_regs_t regs,
    input  logic [31:0]        msg_word,
    input  logic [5:0]         step,
    output logic [31:0]        result
);

    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] f;
    logic [31:0] sum;

    assign x = regs[1];
    assign y = regs[2];
    assign z = regs[3];

    // Select the round function and, in the second and third rounds, add its constant
    always_comb
    begin
        case (step[5:4])
            2'd0:    f = (x & y) | (~x & z);
            2'd1:    f = ((x & y) | (x & z) | (y & z)) + md4_pkg::K_ROUND1;
            default: f = (x ^ y ^ z) + md4_pkg::K_ROUND2;
        endcase
    end

    // Add and rotate
    assign sum    = regs[0] + f + msg_word;
    assign result = md4_pkg::md4_rotl(sum, md4_pkg::md4_rot_amount(step));

endmodule

// File: tb/sv/tb_md4_hash_engine.sv
`timescale 1ns / 1ps
// tb_md4_hash_engine: self-checking bench for the streaming MD4 engine, driving random
// and boundary-length messages under random stalls against an in-bench digest predictor.
// Depends on md4_pkg for the transfer payload types and on md4_hash_engine itself.

module tb_md4_hash_engine;

    localparam logic [31:0] INIT_A     = 32'h67452301;
    localparam logic [31:0] INIT_B     = 32'hefcdab89;
    localparam logic [31:0] INIT_C     = 32'h98badcfe;
    localparam logic [31:0] INIT_D     = 32'h10325476;
    localparam logic [31:0] ROUND2_ADD = 32'h5a827999;
    localparam logic [31:0] ROUND3_ADD = 32'h6ed9eba1;
    localparam logic [31:0] PAD_WORD   = 32'h00000080;

    localparam int WORD_TARGET    = 1350;
    localparam int HOLD_AT_DIGEST = 40;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 250;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int REPORT_LIMIT   = 10;

    // Tracks the chaining value and block fill, and queues the digest each last word yields
    class md4_digest_model;
        logic [31:0]          chain [4];
        logic [31:0]          block_words [16];
        int                   fill;
        logic [63:0]          byte_total;
        md4_pkg::md4_digest_t digests_due [$];
        int                   fault_count;

        function new();
            chain = '{INIT_A, INIT_B, INIT_C, INIT_D};
            fill = 0;
            byte_total = '0;
            fault_count = 0;
        endfunction

        function int shift_of(int r, int j);
            case (r)
                0:       return (j == 0) ? 3 : (j == 1) ? 7 : (j == 2) ? 11 : 19;
                1:       return (j == 0) ? 3 : (j == 1) ? 5 : (j == 2) ? 9 : 13;
                default: return (j == 0) ? 3 : (j == 1) ? 9 : (j == 2) ? 11 : 15;
            endcase
        endfunction

        function logic [31:0] rotl(logic [31:0] v, int s);
            return (v << s) | (v >> (32 - s));
        endfunction

        // Run the 48 steps over the block, rotating the four registers each step
        function void run_block();
            logic [31:0] a, b, c, d, mix, sum;
            logic [3:0]  j;
            int          r, idx;
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            for (int s = 0; s < 48; s++)
            begin
                r = s / 16;
                j = 4'(s % 16);
                case (r)
                    0:
                    begin
                        mix = (b & c) | (~b & d);
                        idx = int'(j);
                    end
                    1:
                    begin
                        mix = ((b & c) | (b & d) | (c & d)) + ROUND2_ADD;
                        idx = (j % 4) * 4 + j / 4;
                    end
                    default:
                    begin
                        mix = (b ^ c ^ d) + ROUND3_ADD;
                        idx = int'({j[0], j[1], j[2], j[3]});
                    end
                endcase
                sum = a + mix + block_words[idx];
                a = d;
                d = c;
                c = b;
                b = rotl(sum, shift_of(r, s % 4));
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
        endfunction

        function void store(logic [31:0] v);
            block_words[fill] = v;
            fill++;
            if (fill == 16)
            begin
                run_block();
                fill = 0;
            end
        endfunction

        // Note one accepted word; on a last word, pad and queue the digest
        function void take_word(md4_pkg::md4_word_t w);
            int                   n;
            logic [31:0]          keep;
            logic [63:0]          bit_len;
            md4_pkg::md4_digest_t due;
            if (w.first_word)
            begin
                chain = '{INIT_A, INIT_B, INIT_C, INIT_D};
                byte_total = '0;
                fill = 0;
            end
            if (!w.last_word)
            begin
                byte_total += 64'd4;
                store(w.data_word);
                return;
            end
            n = (w.byte_count > 3'd4) ? 4 : int'(w.byte_count);
            byte_total += 64'(n);
            bit_len = byte_total << 3;
            if (n == 4)
            begin
                store(w.data_word);
                store(PAD_WORD);
            end
            else
            begin
                keep = (32'd1 << (8 * n)) - 32'd1;
                store((w.data_word & keep) | (PAD_WORD << (8 * n)));
            end
            // No room left for the length: close this block with zeros
            if (fill == 15)
                store('0);
            while (fill < 14)
                store('0);
            store(bit_len[31:0]);
            store(bit_len[63:32]);
            due.digest_a = chain[0];
            due.digest_b = chain[1];
            due.digest_c = chain[2];
            due.digest_d = chain[3];
            digests_due.push_back(due);
            fill = 0;
            byte_total = '0;
        endfunction

        // Compare one accepted digest with the oldest one due
        function void check_digest(md4_pkg::md4_digest_t got);
            md4_pkg::md4_digest_t want;
            if (digests_due.size() == 0)
            begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display("unexpected digest %h %h %h %h",
                             got.digest_a, got.digest_b, got.digest_c, got.digest_d);
                return;
            end
            want = digests_due.pop_front();
            if (got.digest_a !== want.digest_a || got.digest_b !== want.digest_b ||
                got.digest_c !== want.digest_c || got.digest_d !== want.digest_d)
            begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display("digest mismatch: expected %h %h %h %h, got %h %h %h %h",
                             want.digest_a, want.digest_b, want.digest_c, want.digest_d,
                             got.digest_a, got.digest_b, got.digest_c, got.digest_d);
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 word_valid;
    logic                 word_stall;
    md4_pkg::md4_word_t   word;
    logic                 digest_valid;
    logic                 digest_stall;
    md4_pkg::md4_digest_t digest;

    md4_digest_model digest_book;
    int idle_cycles  = 0;
    int words_sent   = 0;
    int send_gap_max = 5;
    int recv_gap_max = 5;

    md4_hash_engine u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .word_valid   (word_valid),
        .word_stall   (word_stall),
        .word         (word),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest       (digest)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Observe transfers on both channels and count cycles without any
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (digest_valid && !digest_stall)
                digest_book.check_digest(digest);
            if (word_valid && !word_stall)
                digest_book.take_word(word);
        end
        if ((digest_valid && !digest_stall) || (word_valid && !word_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Offer one word after a random gap and hold it until the transfer
    task automatic send_word(input logic [31:0] data, input int count,
                             input bit first, input bit last);
        md4_pkg::md4_word_t w;
        int                 gap;
        w.data_word  = data;
        w.byte_count = count[2:0];
        w.first_word = first;
        w.last_word  = last;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            word_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        word_valid <= 1'b1;
        word <= w;
        do @(posedge clk); while (word_stall);
        words_sent++;
    endtask

    // Send one message of random content; a stray restart may land mid-message
    task automatic send_message(input int n_words, input bit fresh);
        bit restart;
        for (int i = 0; i < n_words; i++)
        begin
            restart = (i == 0) ? fresh : ($urandom_range(0, 49) == 0);
            send_word($urandom(), $urandom_range(0, 7), restart, i == n_words - 1);
        end
    endtask

    // Receiver: random stall before each digest, one long hold-off to back up the engine
    initial
    begin
        int pause;
        int taken;
        taken = 0;
        digest_stall <= 1'b0;
        forever
        begin
            pause = $urandom_range(0, recv_gap_max);
            if (taken == HOLD_AT_DIGEST)
                pause += HOLD_CYCLES;
            if (pause > 0)
            begin
                digest_stall <= 1'b1;
                repeat (pause) @(posedge clk);
            end
            digest_stall <= 1'b0;
            do @(posedge clk); while (digest_valid !== 1'b1);
            taken++;
        end
    end

    // Stop a hung run
    initial
    begin
        do @(posedge clk); while (idle_cycles < WATCHDOG_LIMIT);
        $display("tb_md4_hash_engine NOT OK");
        $finish;
    end

    initial
    begin
        int n_words;
        int msg_count;
        digest_book = new();
        rst_n <= 1'b0;
        word_valid <= 1'b0;
        word <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-word messages: empty, every byte count, saturation, chaining on
        send_word(32'h00000000, 0, 1'b0, 1'b1);
        send_word(32'h00000000, 0, 1'b1, 1'b1);
        send_word(32'h00000061, 1, 1'b1, 1'b1);
        send_word(32'hffffffff, 2, 1'b1, 1'b1);
        send_word(32'hffffffff, 3, 1'b1, 1'b1);
        send_word(32'hffffffff, 4, 1'b1, 1'b1);
        send_word(32'h12345678, 5, 1'b1, 1'b1);
        send_word(32'hffffffff, 7, 1'b1, 1'b1);
        send_word(32'h00c0ffee, 3, 1'b0, 1'b1);
        // Short count on a middle word is ignored
        send_word(32'h89abcdef, 2, 1'b1, 1'b0);
        send_word(32'h00000000, 4, 1'b0, 1'b1);
        // Full last word at byte 52: padding spills into an extra block
        for (int i = 0; i < 13; i++)
            send_word(i[0] ? 32'hffffffff : 32'h00000000, 6, i == 0, 1'b0);
        send_word(32'hffffffff, 4, 1'b0, 1'b1);

        // Random messages, lengths biased toward block boundaries
        msg_count = 0;
        while (words_sent < WORD_TARGET)
        begin
            if (msg_count % 8 == 0)
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        send_gap_max = 0;
                        recv_gap_max = 0;
                    end
                    1:
                    begin
                        send_gap_max = 5;
                        recv_gap_max = 0;
                    end
                    2:
                    begin
                        send_gap_max = 0;
                        recv_gap_max = 5;
                    end
                    default:
                    begin
                        send_gap_max = 5;
                        recv_gap_max = 5;
                    end
                endcase
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: n_words = $urandom_range(1, 18);
                5, 6:          n_words = $urandom_range(12, 18);
                7:             n_words = $urandom_range(28, 34);
                8:             n_words = $urandom_range(1, 3);
                default:       n_words = $urandom_range(35, 50);
            endcase
            send_message(n_words, $urandom_range(0, 6) != 0);
            msg_count++;
        end
        word_valid <= 1'b0;

        // Drain outstanding digests, then watch for strays
        while (digest_book.digests_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (digest_book.fault_count == 0 && digest_book.digests_due.size() == 0)
            $display("tb_md4_hash_engine OK");
        else
            $display("tb_md4_hash_engine NOT OK");
        $finish;
    end

endmodule

// File: files.f
src/md4_pkg.sv
src/md4_block_buffer.sv
src/md4_step_unit.sv
src/md4_hash_engine.sv
tb/sv/tb_md4_hash_engine.sv
